[rtl/assert_macros.svh]
// assertion macros shared by the ring line reader rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define URR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define URR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define URR_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define URR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/urr_pkg.sv]
// shared types, codes and constants of the ring line reader
// no dependencies
package urr_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 7;
    localparam int SIZE_W    = 7;
    localparam int STAT_W    = 7;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic signed [STAT_W-1:0] STATUS_OVERFLOW = -7'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECV = 2'd0,
        CMD_READ = 2'd1,
        CMD_LINE = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK  = 2'd0,
        KIND_FWD  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_STAT = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 1'd0,
        REG_SIZE   = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RX,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic enabled;
        logic size_wr;
    } cfg_stat_t;

endpackage

[rtl/urr_if.sv]
// handshake channels of the ring line reader: command, result, configuration
// depends on urr_pkg
interface urr_in_if;
    logic                          valid;
    logic                          ready;
    logic [urr_pkg::CMD_W-1:0]     command;
    logic [urr_pkg::BYTE_W-1:0]    rx_byte;
    logic [urr_pkg::REQ_W-1:0]     request_count;

    modport source (output valid, command, rx_byte, request_count, input ready);
    modport sink   (input valid, command, rx_byte, request_count, output ready);
endinterface

interface urr_out_if;
    logic                              valid;
    logic                              ready;
    logic [urr_pkg::KIND_W-1:0]        result_kind;
    logic [urr_pkg::BYTE_W-1:0]        data_byte;
    logic                              stored;
    logic signed [urr_pkg::STAT_W-1:0] status_count;
    logic                              last;

    modport source (output valid, result_kind, data_byte, stored, status_count, last,
                    input ready);
    modport sink   (input valid, result_kind, data_byte, stored, status_count, last,
                    output ready);
endinterface

interface urr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [urr_pkg::CFG_IDX_W-1:0]    index;
    logic [urr_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/urr_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module urr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/urr_cfg.sv]
// configuration registers: ring enable and ring size with clamped effective size
// depends on urr_pkg, urr_if
module urr_cfg #(
    parameter int RING_DEPTH = urr_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    urr_cfg_if.sink                         cfg,
    output urr_pkg::cfg_stat_t              stat,
    output logic [$clog2(RING_DEPTH+1)-1:0] eff
);

    localparam int CW = $clog2(RING_DEPTH + 1);

    logic                         en_reg;
    logic                         en_next;
    logic [urr_pkg::SIZE_W-1:0]   size_reg;
    logic [urr_pkg::SIZE_W-1:0]   size_next;
    logic                         size_wr;
    logic                         wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_comb
    begin
        en_next   = en_reg;
        size_next = size_reg;
        size_wr   = 1'b0;
        if (wr)
        begin
            unique case (urr_pkg::cfg_reg_t'(cfg.index))
                urr_pkg::REG_ENABLE: en_next = cfg.data[0];
                urr_pkg::REG_SIZE:
                begin
                    size_next = urr_pkg::SIZE_W'(cfg.data);
                    size_wr   = 1'b1;
                end
                default: en_next = en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b0;
            size_reg <= urr_pkg::SIZE_W'(RING_DEPTH);
        end
        else
        begin
            en_reg   <= en_next;
            size_reg <= size_next;
        end
    end

    // clamp to the range the ring supports
    always_comb
    begin
        if (size_reg < urr_pkg::SIZE_W'(2))
        begin
            eff = CW'(2);
        end
        else if (size_reg > urr_pkg::SIZE_W'(RING_DEPTH))
        begin
            eff = CW'(RING_DEPTH);
        end
        else
        begin
            eff = CW'(size_reg);
        end
    end

    assign stat.enabled = en_reg;
    assign stat.size_wr = size_wr;

endmodule

[rtl/urr_seq.sv]
// command sequencer: ring pointers, line scan, pop and result register
// depends on urr_pkg, urr_if; drives the ring ram ports
module urr_seq #(
    parameter int RING_DEPTH = urr_pkg::RING_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    urr_in_if.sink                           cmd,
    urr_out_if.source                        rsp,
    input  urr_pkg::cfg_stat_t               cfg_stat,
    input  logic [$clog2(RING_DEPTH+1)-1:0]  eff,
    output logic                             ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]    ram_waddr,
    output logic [urr_pkg::BYTE_W-1:0]       ram_wdata,
    output logic                             ram_re,
    output logic [$clog2(RING_DEPTH)-1:0]    ram_raddr,
    input  logic [urr_pkg::BYTE_W-1:0]       ram_rdata
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int NW = urr_pkg::REQ_W;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] sz);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= sz) ? '0 : AW'(n);
    endfunction

    urr_pkg::state_t                   state_reg;
    urr_pkg::state_t                   state_next;
    urr_pkg::cmd_t                     cmd_reg;
    urr_pkg::cmd_t                     cmd_next;
    logic [urr_pkg::BYTE_W-1:0]        byte_reg;
    logic [urr_pkg::BYTE_W-1:0]        byte_next;
    logic [AW-1:0]                     wp_reg;
    logic [AW-1:0]                     wp_next;
    logic [AW-1:0]                     rp_reg;
    logic [AW-1:0]                     rp_next;
    logic [AW-1:0]                     ptr_reg;
    logic [AW-1:0]                     ptr_next;
    logic [NW-1:0]                     cnt_reg;
    logic [NW-1:0]                     cnt_next;
    logic [NW-1:0]                     space_reg;
    logic [NW-1:0]                     space_next;
    logic                              over_reg;
    logic                              over_next;
    logic signed [urr_pkg::STAT_W-1:0] status_reg;
    logic signed [urr_pkg::STAT_W-1:0] status_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    urr_pkg::kind_t                    kind_reg;
    urr_pkg::kind_t                    kind_next;
    logic [urr_pkg::BYTE_W-1:0]        data_reg;
    logic [urr_pkg::BYTE_W-1:0]        data_next;
    logic                              stored_reg;
    logic                              stored_next;
    logic signed [urr_pkg::STAT_W-1:0] count_reg;
    logic signed [urr_pkg::STAT_W-1:0] count_next;
    logic                              last_reg;
    logic                              last_next;

    logic                              accept;
    logic                              out_free;
    logic                              at_end;
    logic                              is_term;
    logic                              copy;
    logic [NW-1:0]                     n_new;
    logic                              full_scan;
    logic                              line_bad;
    logic                              emit_go;
    logic [AW-1:0]                     wp_adv;
    logic                              rx_ok;

    assign cmd.ready = (state_reg == urr_pkg::ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign at_end    = (ptr_reg == wp_reg);
    assign is_term   = (ram_rdata == urr_pkg::CH_LF) || (ram_rdata == urr_pkg::CH_CR);
    assign copy      = (space_reg > NW'(1));
    assign n_new     = cnt_reg + NW'(copy);
    assign full_scan = (cnt_reg + NW'(1)) >= NW'(eff);
    assign line_bad  = over_reg || !copy || ((n_new + NW'(1)) >= NW'(eff));
    assign emit_go   = (cnt_reg != '0) && !at_end;
    assign wp_adv    = adv(wp_reg, eff);
    assign rx_ok     = (wp_adv != rp_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            urr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (urr_pkg::cmd_t'(cmd.command))
                        urr_pkg::CMD_RECV: state_next = urr_pkg::ST_RX;
                        urr_pkg::CMD_READ: state_next = urr_pkg::ST_EMIT_RD;
                        urr_pkg::CMD_LINE:
                            state_next = (cfg_stat.enabled && cmd.request_count != '0)
                                ? urr_pkg::ST_SCAN_RD : urr_pkg::ST_STATUS;
                        default: state_next = urr_pkg::ST_IDLE;
                    endcase
                end
            end
            urr_pkg::ST_RX:
                if (out_free) state_next = urr_pkg::ST_IDLE;
            urr_pkg::ST_SCAN_RD:
                state_next = at_end ? urr_pkg::ST_STATUS : urr_pkg::ST_SCAN_CHK;
            urr_pkg::ST_SCAN_CHK:
                state_next = is_term ? urr_pkg::ST_EMIT_RD : urr_pkg::ST_SCAN_RD;
            urr_pkg::ST_EMIT_RD:
                state_next = emit_go ? urr_pkg::ST_EMIT_OUT : urr_pkg::ST_STATUS;
            urr_pkg::ST_EMIT_OUT:
                if (out_free) state_next = urr_pkg::ST_EMIT_RD;
            urr_pkg::ST_STATUS:
                if (out_free) state_next = urr_pkg::ST_IDLE;
            default: state_next = urr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        space_next     = space_reg;
        over_next      = over_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        stored_next    = stored_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = byte_reg;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;

        unique case (state_reg)
            urr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = urr_pkg::cmd_t'(cmd.command);
                    byte_next   = cmd.rx_byte;
                    ptr_next    = rp_reg;
                    space_next  = cmd.request_count;
                    over_next   = 1'b0;
                    status_next = '0;
                    cnt_next    = (urr_pkg::cmd_t'(cmd.command) == urr_pkg::CMD_READ
                                   && cfg_stat.enabled) ? cmd.request_count : '0;
                end
            end
            urr_pkg::ST_RX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    count_next     = '0;
                    if (cfg_stat.enabled)
                    begin
                        kind_next   = urr_pkg::KIND_ACK;
                        data_next   = '0;
                        stored_next = rx_ok;
                        if (rx_ok)
                        begin
                            ram_we  = 1'b1;
                            wp_next = wp_adv;
                        end
                    end
                    else
                    begin
                        kind_next   = urr_pkg::KIND_FWD;
                        data_next   = byte_reg;
                        stored_next = 1'b0;
                    end
                end
            end
            urr_pkg::ST_SCAN_RD:
            begin
                if (at_end)
                begin
                    // every stored byte scanned without a terminator
                    cnt_next = '0;
                    if (full_scan)
                    begin
                        status_next = urr_pkg::STATUS_OVERFLOW;
                        rp_next     = wp_reg;
                    end
                    else
                    begin
                        status_next = '0;
                    end
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            urr_pkg::ST_SCAN_CHK:
            begin
                if (is_term)
                begin
                    rp_next     = adv(ptr_reg, eff);
                    ptr_next    = rp_reg;
                    status_next = line_bad ? urr_pkg::STATUS_OVERFLOW
                                           : urr_pkg::STAT_W'(n_new);
                    cnt_next    = line_bad ? '0 : n_new;
                end
                else
                begin
                    ptr_next   = adv(ptr_reg, eff);
                    cnt_next   = n_new;
                    space_next = copy ? space_reg - NW'(1) : space_reg;
                    over_next  = over_reg || !copy;
                end
            end
            urr_pkg::ST_EMIT_RD:
            begin
                ram_re = emit_go;
            end
            urr_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = urr_pkg::KIND_DATA;
                    data_next      = ram_rdata;
                    stored_next    = 1'b0;
                    count_next     = '0;
                    last_next      = 1'b0;
                    ptr_next       = adv(ptr_reg, eff);
                    cnt_next       = cnt_reg - NW'(1);
                    if (cmd_reg == urr_pkg::CMD_READ)
                    begin
                        status_next = status_reg + urr_pkg::STAT_W'(1);
                    end
                end
            end
            urr_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = urr_pkg::KIND_STAT;
                    data_next      = '0;
                    stored_next    = 1'b0;
                    count_next     = status_reg;
                    last_next      = 1'b1;
                    if (cmd_reg == urr_pkg::CMD_READ)
                    begin
                        rp_next = ptr_reg;
                    end
                end
            end
            default: out_valid_next = out_valid_reg && !rsp.ready;
        endcase

        // a size write empties the ring
        if (cfg_stat.size_wr)
        begin
            wp_next = '0;
            rp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urr_pkg::ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        space_reg  <= space_next;
        over_reg   <= over_next;
        status_reg <= status_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        stored_reg <= stored_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_kind  = kind_reg;
    assign rsp.data_byte    = data_reg;
    assign rsp.stored       = stored_reg;
    assign rsp.status_count = count_reg;
    assign rsp.last         = last_reg;

endmodule

[rtl/uart_rx_ring_line_reader_core.sv]
// receive: accept, then ring write and result register
// read: accept, a ram read and a result word per popped byte, final pointer check, status
// read line: accept, a read and a check per scanned byte, then as read per delivered byte;
// with ring off or a zero request, accept then status; a waiting result word holds the sequencer
// a new command is taken while the previous result still waits in the output register
// reset: ring disabled, size RING_DEPTH, pointers zero; ring contents are not cleared
`include "assert_macros.svh"

module uart_rx_ring_line_reader_core #(
    parameter int RING_DEPTH = urr_pkg::RING_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    urr_in_if.sink     cmd,
    urr_out_if.source  rsp,
    urr_cfg_if.sink    cfg
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    urr_pkg::cfg_stat_t          cfg_stat;
    logic [CW-1:0]               eff;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [urr_pkg::BYTE_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [urr_pkg::BYTE_W-1:0]  ram_rdata;

    urr_cfg #(
        .RING_DEPTH (RING_DEPTH)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .stat  (cfg_stat),
        .eff   (eff)
    );

    urr_seq #(
        .RING_DEPTH (RING_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp       (rsp),
        .cfg_stat  (cfg_stat),
        .eff       (eff),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    urr_ram #(
        .WIDTH (urr_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `URR_ASSERT_ALWAYS(a_no_rw_overlap, clk, rst_n, !(ram_we && ram_re), "read and write overlap")
    `URR_ASSERT_IMPL(a_raddr_in_ring, clk, rst_n, ram_re, CW'(ram_raddr) < eff, "read past ring")
    `URR_ASSERT_IMPL(a_waddr_in_ring, clk, rst_n, ram_we, CW'(ram_waddr) < eff, "write past ring")
    `URR_ASSERT_IMPL(a_wr_enabled, clk, rst_n, ram_we, cfg_stat.enabled, "write with ring off")

endmodule

[tb/uart_rx_ring_line_reader_core_test.sv]
`timescale 1ns / 100ps
// self-checking testbench of uart_rx_ring_line_reader_core: directed table, then random phases
// result words are predicted by an internal ring model or taken from the table, checked in order
// depends on urr_pkg, urr_if and the core rtl
module uart_rx_ring_line_reader_core_test;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 33;
    localparam int PLAN_ROWS     = 30;
    localparam int PRESSURE_PHASE = 4;
    localparam int DEPTH         = urr_pkg::RING_DEPTH_DEF;

    localparam logic [urr_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [urr_pkg::CMD_W-1:0] C_RX     = urr_pkg::CMD_RECV;
    localparam logic [urr_pkg::CMD_W-1:0] C_RD     = urr_pkg::CMD_READ;
    localparam logic [urr_pkg::CMD_W-1:0] C_LN     = urr_pkg::CMD_LINE;
    localparam urr_pkg::cfg_reg_t R_EN = urr_pkg::REG_ENABLE;
    localparam urr_pkg::cfg_reg_t R_SZ = urr_pkg::REG_SIZE;
    localparam logic [urr_pkg::BYTE_W-1:0] B_CR = urr_pkg::CH_CR;
    localparam logic [urr_pkg::BYTE_W-1:0] B_LF = urr_pkg::CH_LF;
    localparam logic signed [urr_pkg::STAT_W-1:0] ST_OVF = urr_pkg::STATUS_OVERFLOW;

    localparam int PHASE_SIZE [PHASES]   = '{64, 3, 64, 1, 100, 8, 33, 5};
    localparam bit PHASE_ENABLE [PHASES] = '{1, 1, 0, 1, 1, 1, 1, 1};
    localparam int IDLE_SRC [4]  = '{0, 58, 0, 38};
    localparam int IDLE_SINK [4] = '{0, 0, 58, 38};

    typedef struct packed {
        urr_pkg::kind_t                    kind;
        logic [urr_pkg::BYTE_W-1:0]        data;
        logic                              stored;
        logic signed [urr_pkg::STAT_W-1:0] count;
        logic                              last;
    } rsp_word_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_op_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_ONE, EXP_NONE} exp_mode_t;

    typedef struct packed {
        row_op_t                    op;
        logic [urr_pkg::CMD_W-1:0]  cmd;
        urr_pkg::cfg_reg_t          reg_idx;
        logic [urr_pkg::BYTE_W-1:0] byte_val;
        logic [urr_pkg::REQ_W-1:0]  arg;
        exp_mode_t                  mode;
        rsp_word_t                  want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    urr_in_if  cmd_if ();
    urr_out_if rsp_if ();
    urr_cfg_if cfg_if ();

    uart_rx_ring_line_reader_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    logic [urr_pkg::BYTE_W-1:0] ring_copy [DEPTH];
    int unsigned                wr_idx;
    int unsigned                rd_idx;
    logic                       mdl_enable;
    logic [urr_pkg::SIZE_W-1:0] mdl_size;

    rsp_word_t fresh_words [$];
    rsp_word_t words_due [$];
    rsp_word_t head_word;
    plan_row_t plan [PLAN_ROWS];

    int fail_count = 0;
    int cmds_taken;
    int quiet_cycles = 0;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_asked = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_word_t ack_word(input logic st);
        rsp_word_t w;
        w = '0;
        w.kind   = urr_pkg::KIND_ACK;
        w.stored = st;
        w.last   = 1'b1;
        return w;
    endfunction

    function automatic rsp_word_t fwd_word(input logic [urr_pkg::BYTE_W-1:0] b);
        rsp_word_t w;
        w = '0;
        w.kind = urr_pkg::KIND_FWD;
        w.data = b;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic rsp_word_t data_word(input logic [urr_pkg::BYTE_W-1:0] b);
        rsp_word_t w;
        w = '0;
        w.kind = urr_pkg::KIND_DATA;
        w.data = b;
        return w;
    endfunction

    function automatic rsp_word_t stat_word(input logic signed [urr_pkg::STAT_W-1:0] cnt);
        rsp_word_t w;
        w = '0;
        w.kind  = urr_pkg::KIND_STAT;
        w.count = cnt;
        w.last  = 1'b1;
        return w;
    endfunction

    function automatic int unsigned ring_span();
        int unsigned s;
        s = mdl_size;
        if (s < 2)
            s = 2;
        if (s > DEPTH)
            s = DEPTH;
        return s;
    endfunction

    function automatic int unsigned ring_next(input int unsigned p);
        int unsigned n;
        n = p + 1;
        if (n >= ring_span())
            n = 0;
        return n;
    endfunction

    function automatic void ring_model_step(input logic [urr_pkg::CMD_W-1:0] c,
                                            input logic [urr_pkg::BYTE_W-1:0] b,
                                            input logic [urr_pkg::REQ_W-1:0] r);
        int unsigned nxt;
        int unsigned ri;
        int unsigned space;
        int unsigned guard;
        int unsigned req_left;
        int n;
        logic complete;
        logic over;
        logic [urr_pkg::BYTE_W-1:0] ch;
        logic [urr_pkg::BYTE_W-1:0] line_buf [DEPTH];
        fresh_words.delete();
        if (c == urr_pkg::CMD_RECV)
        begin
            if (!mdl_enable)
                fresh_words.push_back(fwd_word(b));
            else
            begin
                nxt = ring_next(wr_idx);
                if (nxt != rd_idx)
                begin
                    ring_copy[wr_idx] = b;
                    wr_idx = nxt;
                    fresh_words.push_back(ack_word(1'b1));
                end
                else
                    fresh_words.push_back(ack_word(1'b0));
            end
        end
        else if (c == urr_pkg::CMD_READ)
        begin
            n = 0;
            req_left = r;
            if (mdl_enable)
            begin
                while (req_left > 0 && wr_idx != rd_idx && fresh_words.size() < 63)
                begin
                    fresh_words.push_back(data_word(ring_copy[rd_idx]));
                    rd_idx = ring_next(rd_idx);
                    n++;
                    req_left--;
                end
            end
            fresh_words.push_back(stat_word(n[urr_pkg::STAT_W-1:0]));
        end
        else if (c == urr_pkg::CMD_LINE)
        begin
            if (!mdl_enable || r < 1)
                fresh_words.push_back(stat_word('0));
            else
            begin
                n = 0;
                complete = 1'b0;
                over = 1'b0;
                ri = rd_idx;
                space = r;
                guard = 0;
                while (ri != wr_idx && guard < DEPTH)
                begin
                    ch = ring_copy[ri];
                    guard++;
                    ri = ring_next(ri);
                    if (space > 1 && n < DEPTH)
                    begin
                        line_buf[n] = ch;
                        n++;
                        space--;
                    end
                    else
                        over = 1'b1;
                    if (ch == urr_pkg::CH_LF || ch == urr_pkg::CH_CR)
                    begin
                        complete = 1'b1;
                        rd_idx = ri;
                        if (over)
                            n = -1;
                        break;
                    end
                end
                if (n >= 0 && n + 1 >= ring_span())
                begin
                    n = -1;
                    rd_idx = ri;
                    complete = 1'b1;
                end
                if (!complete)
                    n = 0;
                for (int i = 0; i < n && fresh_words.size() < 63; i++)
                    fresh_words.push_back(data_word(line_buf[i]));
                fresh_words.push_back(stat_word(n[urr_pkg::STAT_W-1:0]));
            end
        end
    endfunction

    task automatic send_cmd(input logic [urr_pkg::CMD_W-1:0] c,
                            input logic [urr_pkg::BYTE_W-1:0] b,
                            input logic [urr_pkg::REQ_W-1:0] r, input exp_mode_t mode,
                            input rsp_word_t want);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= c;
        cmd_if.rx_byte       <= b;
        cmd_if.request_count <= r;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        ring_model_step(c, b, r);
        if (mode == EXP_PRED)
            foreach (fresh_words[i])
                words_due.push_back(fresh_words[i]);
        else if (mode == EXP_ONE)
            words_due.push_back(want);
        if (c != CMD_NONE)
            cmds_taken++;
        @(negedge clk);
    endtask

    task automatic write_reg(input urr_pkg::cfg_reg_t idx,
                             input logic [urr_pkg::CFG_DAT_W-1:0] val);
        cmd_if.valid <= 1'b0;
        while (words_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        if (idx == urr_pkg::REG_ENABLE)
            mdl_enable = val[0];
        else
        begin
            mdl_size = val;
            wr_idx = 0;
            rd_idx = 0;
        end
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (words_due.size() == 0)
            begin
                $error("result word with none due: kind %0d", rsp_if.result_kind);
                fail_count++;
            end
            else
            begin
                head_word = words_due.pop_front();
                check_field("result_kind", head_word.kind, rsp_if.result_kind);
                check_field("data_byte", head_word.data, rsp_if.data_byte);
                check_field("stored", head_word.stored, rsp_if.stored);
                check_field("status_count", head_word.count, rsp_if.status_count);
                check_field("last", head_word.last, rsp_if.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
            || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            || (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : sink_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    initial
    begin : source_side
        int goal;
        int len;
        int pick;
        logic [urr_pkg::REQ_W-1:0] req;
        cmds_taken = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        wr_idx = 0;
        rd_idx = 0;
        mdl_enable = 1'b0;
        mdl_size = urr_pkg::SIZE_W'(DEPTH);
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        cmd_if.valid = 1'b0;
        cmd_if.command = C_RX;
        cmd_if.rx_byte = '0;
        cmd_if.request_count = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = R_EN;
        cfg_if.data = '0;
        rst_n = 1'b0;

        plan = '{
            '{ROW_CMD, C_RX,     R_EN, 8'h00, 7'd0,   EXP_ONE,  fwd_word(8'h00)},
            '{ROW_CMD, C_RX,     R_EN, 8'hFF, 7'd0,   EXP_ONE,  fwd_word(8'hFF)},
            '{ROW_CMD, C_RD,     R_EN, 8'h00, 7'd5,   EXP_ONE,  stat_word(7'sd0)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd10,  EXP_ONE,  stat_word(7'sd0)},
            '{ROW_CMD, CMD_NONE, R_EN, 8'hA5, 7'h7F,  EXP_NONE, '0},
            '{ROW_CFG, C_RX,     R_EN, 8'h00, 7'h7F,  EXP_NONE, '0},
            '{ROW_CMD, C_RX,     R_EN, 8'h41, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, 8'h42, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, B_CR,  7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd0,   EXP_ONE,  stat_word(7'sd0)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd64,  EXP_PRED, '0},
            '{ROW_CMD, C_RX,     R_EN, 8'h78, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, B_LF,  7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RD,     R_EN, 8'h00, 7'd127, EXP_PRED, '0},
            '{ROW_CFG, C_RX,     R_SZ, 8'h00, 7'd2,   EXP_NONE, '0},
            '{ROW_CMD, C_RX,     R_EN, 8'h55, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, 8'hAA, 7'd0,   EXP_ONE,  ack_word(1'b0)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd5,   EXP_ONE,  stat_word(ST_OVF)},
            '{ROW_CFG, C_RX,     R_SZ, 8'h00, 7'd0,   EXP_NONE, '0},
            '{ROW_CMD, C_RX,     R_EN, B_LF,  7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd1,   EXP_ONE,  stat_word(ST_OVF)},
            '{ROW_CFG, C_RX,     R_SZ, 8'h00, 7'd127, EXP_NONE, '0},
            '{ROW_CMD, C_RX,     R_EN, 8'h61, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, 8'h62, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, 8'h63, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_RX,     R_EN, B_LF,  7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd3,   EXP_ONE,  stat_word(ST_OVF)},
            '{ROW_CMD, C_RX,     R_EN, 8'h71, 7'd0,   EXP_ONE,  ack_word(1'b1)},
            '{ROW_CMD, C_LN,     R_EN, 8'h00, 7'd10,  EXP_ONE,  stat_word(7'sd0)},
            '{ROW_CMD, C_RD,     R_EN, 8'h00, 7'd1,   EXP_PRED, '0}
        };

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].arg);
            else
                send_cmd(plan[i].cmd, plan[i].byte_val, plan[i].arg, plan[i].mode,
                         plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(R_EN, {6'($urandom_range(63, 0)), PHASE_ENABLE[p]});
            write_reg(R_SZ, urr_pkg::SIZE_W'(PHASE_SIZE[p]));
            src_idle_pct = IDLE_SRC[p % 4];
            sink_stall_pct = IDLE_SINK[p % 4];
            if (p == PRESSURE_PHASE)
                hold_asked++;
            goal = cmds_taken + PHASE_ITEMS;
            while (cmds_taken < goal)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    // line of random text, terminator, then a read of it
                    len = ($urandom_range(7, 0) == 0) ? $urandom_range(70, 0)
                                                      : $urandom_range(6, 0);
                    for (int i = 0; i < len; i++)
                        send_cmd(C_RX, 8'($urandom_range(255, 0)), 7'($urandom), EXP_PRED,
                                 '0);
                    send_cmd(C_RX, $urandom_range(1, 0) ? B_CR : B_LF, 7'($urandom),
                             EXP_PRED, '0);
                    req = ($urandom_range(3, 0) == 0) ? 7'($urandom_range(127, 0))
                                                      : 7'($urandom_range(len + 3, 0));
                    send_cmd(($urandom_range(3, 0) == 0) ? C_RD : C_LN,
                             8'($urandom), req, EXP_PRED, '0);
                end
                else
                    send_cmd(2'($urandom_range(3, 0)), 8'($urandom), 7'($urandom), EXP_PRED,
                             '0);
            end
        end

        cmd_if.valid <= 1'b0;
        while (words_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
